### hdl/brt_pkg.sv
// ----------------------------------------------------------------------------
// Block residency table package
// Shared types, state codes and the transition legality table.
// ----------------------------------------------------------------------------
`default_nettype none
package brt_pkg;

  localparam int ENTRIES    = 64;
  localparam int COUNT_BITS = 32;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int OUT_CNT_W  = 32;
  localparam int SLICE_W    = (COUNT_BITS < OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

  localparam logic [2:0] FUNC_REGISTER   = 3'd0;
  localparam logic [2:0] FUNC_UNREGISTER = 3'd1;
  localparam logic [2:0] FUNC_REQUEST    = 3'd2;
  localparam logic [2:0] FUNC_GET        = 3'd3;
  localparam logic [2:0] FUNC_ACCESS     = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [2:0] ST_PRESENT    = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOWED = 3'd4;

  localparam logic [3:0] RS_INVALID     = 4'd0;
  localparam logic [3:0] RS_COLD        = 4'd1;
  localparam logic [3:0] RS_MAPPED      = 4'd2;
  localparam logic [3:0] RS_COMPRESSED  = 4'd3;
  localparam logic [3:0] RS_CONVERTING  = 4'd4;
  localparam logic [3:0] RS_PREFETCHING = 4'd5;
  localparam logic [3:0] RS_FAST        = 4'd6;
  localparam logic [3:0] RS_UPGRADING   = 4'd7;
  localparam logic [3:0] RS_DOWNGRADING = 4'd8;
  localparam logic [3:0] RS_EVICTING    = 4'd9;
  localparam logic [3:0] RS_PINNED      = 4'd10;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_LOOKUP,
    CTL_UPDATE,
    CTL_OUTPUT
  } ctl_state_e;

  typedef struct packed {
    logic capture;
    logic update;
  } brt_cmd_t;

  function automatic logic can_move(logic [3:0] from, logic [3:0] to);
    logic [10:0] row;
    begin
      case (from)
        RS_INVALID:     row = 11'b000_0000_0110;
        RS_COLD:        row = 11'b000_0010_0100;
        RS_MAPPED:      row = 11'b000_0110_1000;
        RS_COMPRESSED:  row = 11'b110_1001_0000;
        RS_CONVERTING:  row = 11'b000_0100_1000;
        RS_PREFETCHING: row = 11'b000_0100_1001;
        RS_FAST:        row = 11'b111_0000_0000;
        RS_UPGRADING:   row = 11'b000_0100_1000;
        RS_DOWNGRADING: row = 11'b000_0100_1000;
        RS_EVICTING:    row = 11'b000_0000_0110;
        RS_PINNED:      row = 11'b000_0100_1000;
        default:        row = '0;
      endcase
      can_move = (to <= RS_PINNED) ? row[to] : 1'b0;
    end
  endfunction

endpackage
`default_nettype wire

### hdl/brt_ctrl.sv
// ----------------------------------------------------------------------------
// Block residency table controller
// Sequences lookup, entry update and result handoff for one item.
// ----------------------------------------------------------------------------
`default_nettype none
module brt_ctrl import brt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output brt_cmd_t  cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      CTL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = CTL_LOOKUP;
        end
      end
      CTL_LOOKUP: state_d = CTL_UPDATE;
      CTL_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d = CTL_OUTPUT;
      end
      CTL_OUTPUT: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d = CTL_LOOKUP;
          end else begin
            state_d = CTL_IDLE;
          end
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/brt_datapath.sv
// ----------------------------------------------------------------------------
// Block residency table datapath
// Entry storage, parallel key match, slot selection and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module brt_datapath import brt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  brt_cmd_t         cmd_i,
  input  wire logic [2:0]  func_i,
  input  wire logic [63:0] block_key_i,
  input  wire logic [3:0]  target_state_i,
  input  wire logic [3:0]  target_format_i,
  input  wire logic        is_write_i,
  input  wire logic [47:0] now_tick_i,
  output logic [2:0]       status_o,
  output logic [3:0]       block_state_o,
  output logic             readable_o,
  output logic             writable_o,
  output logic             transitional_o,
  output logic             stable_o,
  output logic [31:0]      access_total_o,
  output logic [31:0]      reads_pending_o,
  output logic [31:0]      writes_pending_o,
  output logic [47:0]      last_access_o,
  output logic [3:0]       format_now_o,
  output logic [31:0]      transitions_total_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = 1;

  logic [ENTRIES-1:0]    valid_q;
  logic [63:0]           key_q    [ENTRIES];
  logic [3:0]            rstate_q [ENTRIES];
  logic [3:0]            fmt_q    [ENTRIES];
  logic [COUNT_BITS-1:0] acc_q    [ENTRIES];
  logic [COUNT_BITS-1:0] rd_q     [ENTRIES];
  logic [COUNT_BITS-1:0] wr_q     [ENTRIES];
  logic [47:0]           tick_q   [ENTRIES];
  logic [COUNT_BITS-1:0] chg_q;

  logic [2:0]  func_q;
  logic [63:0] key_in_q;
  logic [3:0]  tgt_q, tfmt_q;
  logic        isw_q;
  logic [47:0] now_q;

  logic             hit, free_any;
  logic [IDX_W-1:0] hit_idx, free_idx, look_slot;

  always_comb begin
    hit = 1'b0; hit_idx = '0;
    free_any = 1'b0; free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == key_in_q) begin
        hit = 1'b1; hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1; free_idx = IDX_W'(i);
      end
    end
    look_slot = (func_q == FUNC_REGISTER && !hit) ? free_idx : hit_idx;
  end

  logic                  hit_q, free_any_q;
  logic [IDX_W-1:0]      slot_q;
  logic [3:0]            cur_s_q, cur_f_q;
  logic [COUNT_BITS-1:0] cur_a_q, cur_r_q, cur_w_q;
  logic [47:0]           cur_t_q;

  logic [3:0]            res_s;
  logic [3:0]            res_f;
  logic [COUNT_BITS-1:0] res_a, res_r, res_w, res_chg;
  logic [47:0]           res_t;
  logic [2:0]            res_st;
  logic                  res_found;
  logic                  do_reg, do_unreg, do_move, do_acc;

  always_comb begin
    res_s = cur_s_q; res_f = cur_f_q;
    res_a = cur_a_q; res_r = cur_r_q; res_w = cur_w_q; res_t = cur_t_q;
    res_chg = chg_q;
    res_found = hit_q;
    res_st = hit_q ? ST_OK : ST_NOT_FOUND;
    do_reg = 1'b0; do_unreg = 1'b0; do_move = 1'b0; do_acc = 1'b0;
    case (func_q)
      FUNC_REGISTER: begin
        if (hit_q) begin
          res_st = ST_PRESENT;
        end else if (!free_any_q) begin
          res_st = ST_FULL;
        end else begin
          do_reg = 1'b1; res_found = 1'b1; res_st = ST_OK;
          res_s = RS_COLD; res_f = '0; res_a = '0; res_r = '0; res_w = '0; res_t = '0;
        end
      end
      FUNC_UNREGISTER: begin
        if (hit_q) begin
          if (cur_s_q inside {RS_PINNED, RS_CONVERTING, RS_PREFETCHING, RS_UPGRADING,
                              RS_DOWNGRADING, RS_EVICTING}) begin
            res_st = ST_NOT_ALLOWED;
          end else begin
            do_unreg = 1'b1; res_found = 1'b0;
          end
        end
      end
      FUNC_REQUEST: begin
        if (hit_q && cur_s_q != tgt_q) begin
          if (!can_move(cur_s_q, tgt_q)) begin
            res_st = ST_NOT_ALLOWED;
          end else begin
            do_move = 1'b1;
            res_s = tgt_q;
            if (tgt_q inside {RS_CONVERTING, RS_UPGRADING, RS_DOWNGRADING}) res_f = tfmt_q;
            if (chg_q != CNT_MAX) res_chg = chg_q + CNT_ONE;
          end
        end
      end
      FUNC_ACCESS: begin
        if (hit_q) begin
          do_acc = 1'b1;
          res_t = now_q;
          if (cur_a_q != CNT_MAX) res_a = cur_a_q + CNT_ONE;
          if (isw_q) begin
            if (cur_w_q != CNT_MAX) res_w = cur_w_q + CNT_ONE;
          end else begin
            if (cur_r_q != CNT_MAX) res_r = cur_r_q + CNT_ONE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      chg_q   <= '0;
    end else if (cmd_i.update) begin
      if (do_reg) valid_q[slot_q] <= 1'b1;
      if (do_unreg) valid_q[slot_q] <= 1'b0;
      chg_q <= res_chg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i; key_in_q <= block_key_i; tgt_q <= target_state_i;
      tfmt_q <= target_format_i; isw_q <= is_write_i; now_q <= now_tick_i;
    end
    hit_q      <= hit;
    free_any_q <= free_any;
    slot_q     <= look_slot;
    cur_s_q    <= rstate_q[look_slot];
    cur_f_q    <= fmt_q[look_slot];
    cur_a_q    <= acc_q[look_slot];
    cur_r_q    <= rd_q[look_slot];
    cur_w_q    <= wr_q[look_slot];
    cur_t_q    <= tick_q[look_slot];
    if (cmd_i.update && (do_reg || do_move || do_acc)) begin
      if (do_reg) key_q[slot_q] <= key_in_q;
      rstate_q[slot_q] <= res_s; fmt_q[slot_q] <= res_f;
      acc_q[slot_q] <= res_a; rd_q[slot_q] <= res_r; wr_q[slot_q] <= res_w;
      tick_q[slot_q] <= res_t;
    end
    if (cmd_i.update) begin
      status_o            <= res_st;
      transitions_total_o <= OUT_CNT_W'(res_chg[SLICE_W-1:0]);
      if (res_found) begin
        block_state_o    <= res_s;
        readable_o       <= res_s inside {RS_COMPRESSED, RS_FAST, RS_PINNED};
        writable_o       <= res_s inside {RS_FAST, RS_PINNED};
        transitional_o   <= res_s inside {RS_CONVERTING, RS_PREFETCHING, RS_UPGRADING,
                                          RS_DOWNGRADING, RS_EVICTING};
        stable_o         <= res_s inside {RS_COMPRESSED, RS_FAST, RS_PINNED,
                                          RS_COLD, RS_MAPPED};
        access_total_o   <= OUT_CNT_W'(res_a[SLICE_W-1:0]);
        reads_pending_o  <= OUT_CNT_W'(res_r[SLICE_W-1:0]);
        writes_pending_o <= OUT_CNT_W'(res_w[SLICE_W-1:0]);
        last_access_o    <= res_t;
        format_now_o     <= res_f;
      end else begin
        block_state_o <= RS_INVALID; readable_o <= 1'b0; writable_o <= 1'b0;
        transitional_o <= 1'b0; stable_o <= 1'b0; access_total_o <= '0;
        reads_pending_o <= '0; writes_pending_o <= '0; last_access_o <= '0;
        format_now_o <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/block_residency_table_top.sv
// ----------------------------------------------------------------------------
// Block residency table
// Keyed table of memory block residency states with access counters.
//
//   Channel | Direction | Handshake
//   input   | in        | in_valid_i / in_ready_o
//   result  | out       | out_valid_o / out_ready_i
//
// Each item passes through capture, a parallel key match that registers
// the selected entry, then the read-modify-write of that entry into the result
// register. A new item is taken in the same cycle the held result transfers.
// Reset clears all entry valid bits and the transition count at once.
// A stalled result holds the block; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none
module block_residency_table_top import brt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [63:0] block_key_i,
  input  wire logic [3:0]  target_state_i,
  input  wire logic [3:0]  target_format_i,
  input  wire logic        is_write_i,
  input  wire logic [47:0] now_tick_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [3:0]       block_state_o,
  output logic             readable_o,
  output logic             writable_o,
  output logic             transitional_o,
  output logic             stable_o,
  output logic [31:0]      access_total_o,
  output logic [31:0]      reads_pending_o,
  output logic [31:0]      writes_pending_o,
  output logic [47:0]      last_access_o,
  output logic [3:0]       format_now_o,
  output logic [31:0]      transitions_total_o
);

  brt_cmd_t cmd;

  brt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd)
  );

  brt_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .func_i, .block_key_i, .target_state_i,
    .target_format_i, .is_write_i, .now_tick_i, .status_o, .block_state_o,
    .readable_o, .writable_o, .transitional_o, .stable_o, .access_total_o,
    .reads_pending_o, .writes_pending_o, .last_access_o, .format_now_o,
    .transitions_total_o
  );

endmodule
`default_nettype wire
